// File: rtl/smbc_pkg.sv
// ----------------------------------------------------------------------------
// smbc_pkg
// Shared types and constants for the shift motor bridge control unit.
// ----------------------------------------------------------------------------
package smbc_pkg;

  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgStallLimitShort = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStallLimitLong  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgShortLimitTask  = 2'd2;

  localparam logic [31:0] StallLimitShortRst = 32'd199;
  localparam logic [31:0] StallLimitLongRst  = 32'd1999;
  localparam logic [7:0]  ShortLimitTaskRst  = 8'd2;

  // target codes
  localparam logic [7:0] TgtForward = 8'd0;
  localparam logic [7:0] TgtReverse = 8'd1;
  localparam logic [7:0] TgtArrived = 8'd2;

  // direction write commands
  localparam logic [1:0] DirWrKeep    = 2'd0;
  localparam logic [1:0] DirWrForward = 2'd1;
  localparam logic [1:0] DirWrReverse = 2'd2;
  localparam logic [1:0] DirWrClear   = 2'd3;

  // queued direction codes
  localparam logic [1:0] DirIdle    = 2'd0;
  localparam logic [1:0] DirForward = 2'd1;
  localparam logic [1:0] DirReverse = 2'd2;

  typedef struct packed {
    logic [31:0] stall_limit_short;
    logic [31:0] stall_limit_long;
    logic [7:0]  short_limit_task;
  } smbc_cfg_t;

  typedef struct packed {
    logic        target_write;
    logic [7:0]  new_target;
    logic [1:0]  dir_write;
    logic        encoder_level;
    logic [31:0] tick_now;
    logic [7:0]  task_id;
  } smbc_in_t;

  typedef struct packed {
    logic        pin_a_level;
    logic        pin_b_level;
    logic [7:0]  gear_position;
    logic        running;
    logic        arrived_pulse;
    logic        demote_task;
    logic [7:0]  target_now;
  } smbc_out_t;

  typedef struct packed {
    logic [7:0]  target_code;
    logic [1:0]  queued_direction;
    logic        encoder_mirror;
    logic [7:0]  gear_count;
    logic        stall_flag;
    logic        window_latched;
    logic [31:0] window_start;
    logic        drive_on;
    logic        pin_a;
    logic        pin_b;
  } smbc_state_t;

  localparam smbc_state_t StateRst = '{
    target_code:      TgtArrived,
    queued_direction: DirIdle,
    encoder_mirror:   1'b0,
    gear_count:       8'd0,
    stall_flag:       1'b0,
    window_latched:   1'b0,
    window_start:     32'd0,
    drive_on:         1'b0,
    pin_a:            1'b0,
    pin_b:            1'b0
  };

endpackage

// File: rtl/smbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// smbc_cfg_regs
// Stall limit and short-limit task registers behind the plain write port.
// ----------------------------------------------------------------------------
module smbc_cfg_regs import smbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output smbc_cfg_t           cfg_o
);

  smbc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_limit_short <= StallLimitShortRst;
      cfg_q.stall_limit_long  <= StallLimitLongRst;
      cfg_q.short_limit_task  <= ShortLimitTaskRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStallLimitShort: cfg_q.stall_limit_short <= cfg_data_i;
        CfgStallLimitLong:  cfg_q.stall_limit_long  <= cfg_data_i;
        CfgShortLimitTask:  cfg_q.short_limit_task  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/smbc_pass_logic.sv
// ----------------------------------------------------------------------------
// smbc_pass_logic
// One control-loop pass: target and direction load, bridge drive, encoder
// edge counting, stall window check and brake on stall.
// ----------------------------------------------------------------------------
module smbc_pass_logic import smbc_pkg::*; (
  input  smbc_state_t state_i,
  input  smbc_in_t    item_i,
  input  smbc_cfg_t   cfg_i,
  output smbc_state_t state_o,
  output smbc_out_t   result_o
);

  smbc_state_t st;
  logic        drive;
  logic        short_task;
  logic [31:0] limit;
  logic [31:0] elapsed;
  logic        arrived;

  assign short_task = (item_i.task_id == cfg_i.short_limit_task);
  assign limit      = short_task ? cfg_i.stall_limit_short : cfg_i.stall_limit_long;

  always_comb begin
    st      = state_i;
    arrived = 1'b0;
    elapsed = 32'd0;

    if (item_i.target_write) begin
      st.target_code = item_i.new_target;
    end
    case (item_i.dir_write)
      DirWrForward: st.queued_direction = DirForward;
      DirWrReverse: st.queued_direction = DirReverse;
      DirWrClear:   st.queued_direction = DirIdle;
      default: ;
    endcase

    drive = (st.target_code == TgtForward) || (st.target_code == TgtReverse);

    if (drive) begin
      st.pin_a = (st.target_code == TgtForward);
      st.pin_b = (st.target_code != TgtForward);
      // encoder edge moves the gear counter only with a queued direction
      if (item_i.encoder_level != st.encoder_mirror) begin
        if (st.queued_direction == DirForward) begin
          st.gear_count     = st.gear_count - 8'd1;
          st.window_latched = 1'b0;
        end else if (st.queued_direction == DirReverse) begin
          st.gear_count     = st.gear_count + 8'd1;
          st.window_latched = 1'b0;
        end
        st.encoder_mirror = item_i.encoder_level;
      end
      st.drive_on = 1'b1;
      if (!st.window_latched) begin
        st.window_start   = item_i.tick_now;
        st.window_latched = 1'b1;
      end
      elapsed = item_i.tick_now - st.window_start;
      if (elapsed > limit) begin
        st.stall_flag = 1'b1;
      end
    end

    // brake; a stall pending while arrived waits for another target
    if (st.stall_flag && (st.target_code != TgtArrived)) begin
      st.target_code      = TgtArrived;
      st.pin_a            = 1'b1;
      st.pin_b            = 1'b1;
      st.drive_on         = 1'b0;
      arrived             = 1'b1;
      st.queued_direction = DirIdle;
      st.stall_flag       = 1'b0;
      st.window_latched   = 1'b0;
    end
  end

  assign state_o = st;

  assign result_o.pin_a_level   = st.pin_a;
  assign result_o.pin_b_level   = st.pin_b;
  assign result_o.gear_position = st.gear_count;
  assign result_o.running       = st.drive_on;
  assign result_o.arrived_pulse = arrived;
  assign result_o.demote_task   = arrived & short_task;
  assign result_o.target_now    = st.target_code;

endmodule

// File: rtl/shift_motor_bridge_control_unit.sv
// ----------------------------------------------------------------------------
// shift_motor_bridge_control_unit
// a result is in the output register in the cycle after its transaction is accepted
// throughput: one item per cycle while results are taken, set by the state update loop
// an occupied output register that is not taken holds off the input side
// reset: asynchronous active low; target arrived, direction idle, pins low,
// counters and stall window cleared, limits back to 199 / 1999, task 2
// ----------------------------------------------------------------------------
module shift_motor_bridge_control_unit import smbc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // target_write, new_target[7:0], dir_write[1:0], encoder_level,
  // tick_now[31:0], task_id[7:0], zero fill
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pin_a_level, pin_b_level, gear_position[7:0], running, arrived_pulse,
  // demote_task, target_now[7:0], zero fill
  output logic [OutTdataW-1:0] m_axis_tdata,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  smbc_cfg_t   cfg;
  smbc_in_t    item;
  smbc_state_t state_q, state_d;
  smbc_out_t   result_d, result_q;
  logic        out_valid_q;
  logic        accept;

  smbc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign item.target_write  = s_axis_tdata[0];
  assign item.new_target    = s_axis_tdata[8:1];
  assign item.dir_write     = s_axis_tdata[10:9];
  assign item.encoder_level = s_axis_tdata[11];
  assign item.tick_now      = s_axis_tdata[43:12];
  assign item.task_id       = s_axis_tdata[51:44];

  smbc_pass_logic u_pass (
    .state_i  (state_q),
    .item_i   (item),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (result_d)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateRst;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          result_q.target_now,
                          result_q.demote_task,
                          result_q.arrived_pulse,
                          result_q.running,
                          result_q.gear_position,
                          result_q.pin_b_level,
                          result_q.pin_a_level};

`ifndef NO_ASSERTIONS
  // a demotion only comes with a brake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!result_q.demote_task || result_q.arrived_pulse))
    else $error("demote without arrival");

  // a brake leaves the bridge stopped, both pins high, target arrived
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result_q.arrived_pulse) |->
      (!result_q.running && result_q.pin_a_level && result_q.pin_b_level &&
       (result_q.target_now == TgtArrived)))
    else $error("brake result inconsistent");

  // the reported target is the one held in state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (result_q.target_now == state_q.target_code))
    else $error("target out of step with state");

  // the output register never blocks input while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("ready low with empty output");

  // the state only changes on an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q))
    else $error("state moved without a transaction");
`endif

endmodule
